// File: hdl/mdr_pkg.sv
// ----------------------------------------------------------------------------
// mdr_pkg: shared types and constants for the motor direction controller
// Field widths, configuration register indexes and the command/result
// structs passed between the top level and the mode machine.
// ----------------------------------------------------------------------------
package mdr_pkg;

  localparam int unsigned DutyW  = 14;
  localparam int unsigned StepW  = 10;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned LedW   = 11;

  // Full-scale duty in units of 1/10000; goals above it are clipped.
  localparam int unsigned DutyFullScale = 10000;

  // Reset values of the configuration registers.
  localparam logic [StepW-1:0] RampStepRst      = StepW'(50);
  localparam logic [DutyW-1:0] StopThresholdRst = DutyW'(10);

  typedef enum logic [0:0] {
    RegRampStep      = 1'b0,
    RegStopThreshold = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             clear;
    logic [DutyW-1:0] goal;
    logic             reverse;
    logic             enable;
  } cmd_t;

  typedef struct packed {
    logic [LedW-1:0]  led_period;
    logic [ModeW-1:0] mode;
    logic             bridge_reverse;
    logic [DutyW-1:0] duty;
  } res_t;

endpackage

// File: hdl/mdr_ramp.sv
// ----------------------------------------------------------------------------
// mdr_ramp: slew-rate limiter for the bridge duty
// Moves the duty one step toward the setpoint, snapping when within a step.
// ----------------------------------------------------------------------------
module mdr_ramp (
  input  logic [mdr_pkg::DutyW-1:0] duty_now_i,
  input  logic [mdr_pkg::DutyW-1:0] setpoint_i,
  input  logic [mdr_pkg::StepW-1:0] step_i,
  output logic [mdr_pkg::DutyW-1:0] duty_next_o
);

  logic [mdr_pkg::DutyW-1:0] step_ext;
  logic [mdr_pkg::DutyW-1:0] err;

  assign step_ext = {{(mdr_pkg::DutyW - mdr_pkg::StepW){1'b0}}, step_i};

  always_comb begin
    if (setpoint_i > duty_now_i) begin
      err         = setpoint_i - duty_now_i;
      duty_next_o = (err > step_ext) ? duty_now_i + step_ext : setpoint_i;
    end else begin
      err         = duty_now_i - setpoint_i;
      duty_next_o = (err > step_ext) ? duty_now_i - step_ext : setpoint_i;
    end
  end

endmodule

// File: hdl/mdr_fsm.sv
// ----------------------------------------------------------------------------
// mdr_fsm: stopped/stopping/forward/reverse mode machine
// Holds duty, setpoint, mode and direction; advances once per tick.
// ----------------------------------------------------------------------------
module mdr_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  mdr_pkg::cmd_t             cmd_i,
  input  logic [mdr_pkg::StepW-1:0] ramp_step_i,
  input  logic [mdr_pkg::DutyW-1:0] stop_threshold_i,
  output mdr_pkg::res_t             res_o
);

  typedef enum logic [mdr_pkg::ModeW-1:0] {
    ModeStopped  = 2'd0,
    ModeStopping = 2'd1,
    ModeForward  = 2'd2,
    ModeReverse  = 2'd3
  } mode_e;

  localparam logic [16:0] FullScaleW = 17'(mdr_pkg::DutyFullScale);
  localparam logic [mdr_pkg::DutyW-1:0] FullScaleN = mdr_pkg::DutyW'(mdr_pkg::DutyFullScale);
  localparam logic [mdr_pkg::LedW-1:0] LedStopped  = mdr_pkg::LedW'(2000);
  localparam logic [mdr_pkg::LedW-1:0] LedStopping = mdr_pkg::LedW'(1000);
  localparam logic [mdr_pkg::LedW-1:0] LedRunning  = mdr_pkg::LedW'(250);

  mode_e                     mode_q, mode_d;
  logic [mdr_pkg::DutyW-1:0] duty_q, duty_d;
  logic [mdr_pkg::DutyW-1:0] setpoint_q, setpoint_d;
  logic                      rev_q, rev_d;
  logic [mdr_pkg::DutyW-1:0] ramp_sp;
  logic [mdr_pkg::DutyW-1:0] goal_sat;
  logic                      enable;

  // Clear drops the stored setpoint before the ramp.
  assign ramp_sp  = cmd_i.clear ? '0 : setpoint_q;
  assign enable   = cmd_i.enable & ~cmd_i.clear;
  assign goal_sat = ({3'b000, cmd_i.goal} > FullScaleW) ? FullScaleN : cmd_i.goal;

  mdr_ramp u_ramp (
    .duty_now_i  (duty_q),
    .setpoint_i  (ramp_sp),
    .step_i      (ramp_step_i),
    .duty_next_o (duty_d)
  );

  always_comb begin
    mode_d     = mode_q;
    rev_d      = rev_q;
    setpoint_d = '0;
    unique case (mode_q)
      ModeStopped: begin
        if (enable) begin
          rev_d  = cmd_i.reverse;
          mode_d = cmd_i.reverse ? ModeReverse : ModeForward;
        end
      end
      ModeStopping: begin
        if (duty_d <= stop_threshold_i) begin
          mode_d = ModeStopped;
        end
      end
      ModeForward: begin
        setpoint_d = goal_sat;
        if (cmd_i.reverse || !enable) begin
          mode_d = ModeStopping;
        end
      end
      ModeReverse: begin
        setpoint_d = goal_sat;
        if (!cmd_i.reverse || !enable) begin
          mode_d = ModeStopping;
        end
      end
      default: begin
        mode_d = ModeStopping;
      end
    endcase
  end

  always_comb begin
    res_o.duty           = duty_d;
    res_o.bridge_reverse = rev_d;
    res_o.mode           = mode_d;
    unique case (mode_d)
      ModeStopped:  res_o.led_period = LedStopped;
      ModeStopping: res_o.led_period = LedStopping;
      default:      res_o.led_period = LedRunning;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeStopping;
      duty_q     <= '0;
      setpoint_q <= '0;
      rev_q      <= 1'b0;
    end else if (tick_i) begin
      mode_q     <= mode_d;
      duty_q     <= duty_d;
      setpoint_q <= setpoint_d;
      rev_q      <= rev_d;
    end
  end

endmodule

// File: hdl/motor_direction_fsm_with_duty_ramp.sv
// ----------------------------------------------------------------------------
// motor_direction_fsm_with_duty_ramp: direction state machine with duty ramp
// Path: a command accepted into the input register advances into the result
//   register and is then valid on the master side (input register, then
//   result register); it waits while the result register is full and stalled.
// Throughput: one command per cycle while the result stream is not stalled.
// Reset (rst_ni low, asynchronous): both stages empty, mode stopping, duty
//   and setpoint zero, forward direction, ramp_step 50, stop_threshold 10.
// ----------------------------------------------------------------------------
module motor_direction_fsm_with_duty_ramp (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] enable_cmd, [1] reverse_cmd, [15:2] duty_goal, [16] clear_cmd, rest zero
  input  logic [23:0] s_axis_tdata,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] duty_out, [14] bridge_reverse, [16:15] mode_out, [27:17] led_period,
  // [31:28] zero
  output logic [31:0] m_axis_tdata,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_addr_i,
  input  logic [13:0] cfg_data_i
);

  // Input register stage
  logic          in_valid_q;
  mdr_pkg::cmd_t in_cmd_q;
  // Result register stage
  logic          out_valid_q;
  mdr_pkg::res_t out_res_q;
  mdr_pkg::res_t res;
  // Configuration registers
  logic [mdr_pkg::StepW-1:0] ramp_step_q;
  logic [mdr_pkg::DutyW-1:0] stop_threshold_q;

  logic advance;
  logic accept;

  // Advance the held command into the result register whenever that register
  // is empty or its transaction completes this cycle.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Payload needs no reset; load only on an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q.enable  <= s_axis_tdata[0];
      in_cmd_q.reverse <= s_axis_tdata[1];
      in_cmd_q.goal    <= s_axis_tdata[15:2];
      in_cmd_q.clear   <= s_axis_tdata[16];
    end
  end

  // Mode machine: ramp, then mode transition; state moves only on advance.
  mdr_fsm u_fsm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (advance),
    .cmd_i            (in_cmd_q),
    .ramp_step_i      (ramp_step_q),
    .stop_threshold_i (stop_threshold_q),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q};

  // Accept configuration at any time; the source must write only while no
  // transaction is in flight, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q      <= mdr_pkg::RampStepRst;
      stop_threshold_q <= mdr_pkg::StopThresholdRst;
    end else if (cfg_valid_i) begin
      unique case (mdr_pkg::cfg_reg_e'(cfg_addr_i))
        mdr_pkg::RegRampStep:      ramp_step_q      <= cfg_data_i[mdr_pkg::StepW-1:0];
        mdr_pkg::RegStopThreshold: stop_threshold_q <= cfg_data_i;
        default:                   ramp_step_q      <= ramp_step_q;
      endcase
    end
  end

  // A held command that cannot advance must still be held next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("held command lost");

  // Each advance produces a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced command produced no result");

  // The LED prescaler matches the reported mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      (out_res_q.mode == 2'd0 && out_res_q.led_period == 11'd2000) ||
      (out_res_q.mode == 2'd1 && out_res_q.led_period == 11'd1000) ||
      (out_res_q.mode[1] && out_res_q.led_period == 11'd250))
    else $error("led period inconsistent with mode");

endmodule
